FILE: rtl/periodic_timer_table_top_assert.svh
// Assertion helpers shared by the timer table modules.
`ifndef PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define PTT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PTT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ptt_pkg.sv
package ptt_pkg;

   localparam int NUM_TIMERS_DEF = 16;

   localparam int OP_W   = 2;
   localparam int KIND_W = 2;
   localparam int ID_W   = 32;
   localparam int TIME_W = 48;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOFIRE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   // datapath -> sequencer
   typedef struct packed {
      logic start;
      logic hit;
      logic stall;
      logic out_free;
   } seq_stat_type;

   // sequencer -> datapath
   typedef struct packed {
      logic idle;
      logic fin;
      logic rd_en;
      logic eval_vld;
   } seq_ctrl_type;

endpackage

FILE: rtl/ptt_if.sv
interface ptt_req_if;
   logic                         valid;
   logic                         ready;
   logic [ptt_pkg::OP_W-1:0]     operation;
   logic [ptt_pkg::ID_W-1:0]     period_ms;
   logic [ptt_pkg::ID_W-1:0]     cancel_id;
   logic [ptt_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, output operation, output period_ms,
                   output cancel_id, output now_ms, input ready);
   modport sink   (input valid, input operation, input period_ms,
                   input cancel_id, input now_ms, output ready);
endinterface

interface ptt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ptt_pkg::KIND_W-1:0]   kind;
   logic [ptt_pkg::ID_W-1:0]     tmr_id;
   logic                         ok;
   logic                         last;

   modport source (output valid, output kind, output tmr_id, output ok,
                   output last, input ready);
   modport sink   (input valid, input kind, input tmr_id, input ok,
                   input last, output ready);
endinterface

FILE: rtl/ptt_ram.sv
module ptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ptt_alu.sv
// Shared deadline unit: saturating add of a period to a time, and time compare.
module ptt_alu (
   input  logic [ptt_pkg::TIME_W-1:0] base,
   input  logic [ptt_pkg::ID_W-1:0]   addend,
   input  logic [ptt_pkg::TIME_W-1:0] limit,
   output logic [ptt_pkg::TIME_W-1:0] sum_sat,
   output logic                       ge
);

   localparam int SW = ptt_pkg::TIME_W + 1;

   logic [SW-1:0] sum_full;

   assign sum_full = SW'(base) + SW'(addend);
   assign sum_sat  = sum_full[SW-1] ? '1 : sum_full[SW-2:0];
   assign ge       = (base >= limit);

endmodule

FILE: rtl/ptt_seq.sv
`include "periodic_timer_table_top_assert.svh"

// Slot scan sequencer: one table read a cycle unless held, evaluated next cycle.
module ptt_seq #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
   localparam int CW = $clog2(NUM_TIMERS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptt_pkg::seq_stat_type stat,
   output ptt_pkg::seq_ctrl_type ctrl,
   output logic [IW-1:0]         rd_addr,
   output logic [IW-1:0]         eval_idx
);

   ptt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               eval_vld_ff, eval_vld_in;
   logic [IW-1:0]      eval_idx_ff, eval_idx_in;

   logic adv;
   logic more;
   logic scan_done;

   assign more      = (issue_ff < CW'(NUM_TIMERS));
   assign scan_done = !more && !eval_vld_ff;
   assign adv       = (state_ff == ptt_pkg::ST_SCAN) && !stat.stall && !stat.hit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (stat.start) state_in = ptt_pkg::ST_SCAN;
         end
         ptt_pkg::ST_SCAN: begin
            if (stat.hit || scan_done) state_in = ptt_pkg::ST_FIN;
         end
         ptt_pkg::ST_FIN: begin
            if (stat.out_free) state_in = ptt_pkg::ST_IDLE;
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   // scan counters
   always_comb begin
      issue_in    = issue_ff;
      eval_vld_in = eval_vld_ff;
      eval_idx_in = eval_idx_ff;
      if (stat.start) begin
         issue_in    = '0;
         eval_vld_in = 1'b0;
      end else if (adv) begin
         eval_vld_in = more;
         eval_idx_in = issue_ff[IW-1:0];
         if (more) issue_in = issue_ff + CW'(1);
      end
   end

   // outputs
   always_comb begin
      ctrl.idle     = (state_ff == ptt_pkg::ST_IDLE);
      ctrl.fin      = (state_ff == ptt_pkg::ST_FIN);
      ctrl.eval_vld = (state_ff == ptt_pkg::ST_SCAN) && eval_vld_ff;
      ctrl.rd_en    = adv && more;
      rd_addr       = issue_ff[IW-1:0];
      eval_idx      = eval_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ptt_pkg::ST_IDLE;
         issue_ff    <= '0;
         eval_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         issue_ff    <= issue_in;
         eval_vld_ff <= eval_vld_in;
      end
      eval_idx_ff <= eval_idx_in;
   end

   `PTT_ASSERT_IMP(a_issue_bound, clock, reset, 1'b1, issue_ff <= CW'(NUM_TIMERS), "scan count overran table")
   `PTT_ASSERT_NXT(a_fin_waits, clock, reset, (state_ff == ptt_pkg::ST_FIN) && !stat.out_free, state_ff == ptt_pkg::ST_FIN, "final result dropped while output busy")

endmodule

FILE: rtl/periodic_timer_table_top.sv
// Channel  Dir  Modport        Payload
// req_if   in   ptt_req_if     operation, period_ms, cancel_id, now_ms
// rsp_if   out  ptt_rsp_if     kind, tmr_id, ok, last
//
// Each transaction scans the table one slot a cycle, unless a tick stalls,
// through the slot RAMs and the shared deadline unit; the last result is
// registered once the scan has finished and the output register is free,
// and ready returns with it. An add or cancel that finds its slot ends the
// scan early; an unused operation code starts no scan. req_if.ready is high
// only between transactions.
// A tick stalls on a second fire while the output register is still occupied.
// Reset is synchronous; it clears active bits, valid flags and tick time, and sets the next id to one.
`include "periodic_timer_table_top_assert.svh"

module periodic_timer_table_top #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ptt_req_if.sink   req_if,
   ptt_rsp_if.source rsp_if
);

   localparam int IW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int IDW = ptt_pkg::ID_W;
   localparam int TW  = ptt_pkg::TIME_W;
   localparam int KW  = ptt_pkg::KIND_W;

   ptt_pkg::seq_stat_type stat;
   ptt_pkg::seq_ctrl_type ctrl;
   logic [IW-1:0]         rd_addr;
   logic [IW-1:0]         eval_idx;

   logic [ptt_pkg::OP_W-1:0] op_ff, op_in;
   logic [IDW-1:0]           interval_ff, interval_in;
   logic [IDW-1:0]           cid_ff, cid_in;
   logic [TW-1:0]            last_tick_ff, last_tick_in;
   logic [IDW-1:0]           next_id_ff, next_id_in;
   logic [NUM_TIMERS-1:0]    active_ff, active_in;

   logic                     pend_vld_ff, pend_vld_in;
   logic [KW-1:0]            pend_kind_ff, pend_kind_in;
   logic [IDW-1:0]           pend_id_ff, pend_id_in;
   logic                     pend_ok_ff, pend_ok_in;

   logic                     rsp_vld_ff, rsp_vld_in;
   logic [KW-1:0]            rsp_kind_ff, rsp_kind_in;
   logic [IDW-1:0]           rsp_id_ff, rsp_id_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [2*IDW-1:0] meta_rd;
   logic [IDW-1:0]   id_rd;
   logic [IDW-1:0]   period_rd;
   logic [TW-1:0]    dl_rd;
   logic [TW-1:0]    dl_sum;
   logic             dl_ge;

   logic             accept;
   logic             is_add, is_cancel, is_tick;
   logic             slot_on;
   logic             add_hit, cancel_hit, fire, fire_go;
   logic             out_free;
   logic [IDW-1:0]   next_id_inc;
   logic             add_ok_out;
   logic             single_out;

   assign accept    = req_if.valid && ctrl.idle;
   assign is_add    = (op_ff == ptt_pkg::OP_ADD);
   assign is_cancel = (op_ff == ptt_pkg::OP_CANCEL);
   assign is_tick   = (op_ff == ptt_pkg::OP_TICK);

   assign id_rd     = meta_rd[2*IDW-1:IDW];
   assign period_rd = meta_rd[IDW-1:0];
   assign slot_on   = active_ff[eval_idx];

   assign add_hit    = ctrl.eval_vld && is_add && !slot_on;
   assign cancel_hit = ctrl.eval_vld && is_cancel && slot_on &&
                       (cid_ff != '0) && (id_rd == cid_ff);
   assign fire       = ctrl.eval_vld && is_tick && slot_on && dl_ge;
   assign out_free   = !rsp_vld_ff || rsp_if.ready;
   // a second fire pushes the held one out, which needs a free output register
   assign stat.stall = fire && pend_vld_ff && !out_free;
   assign fire_go    = fire && !stat.stall;

   assign stat.start    = accept && (req_if.operation != ptt_pkg::OP_UNUSED);
   assign stat.hit      = add_hit || cancel_hit;
   assign stat.out_free = out_free;

   // identifier zero is never handed out
   assign next_id_inc = (next_id_ff + IDW'(1) == '0) ? IDW'(1) : next_id_ff + IDW'(1);

   ptt_seq #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .stat     (stat),
      .ctrl     (ctrl),
      .rd_addr  (rd_addr),
      .eval_idx (eval_idx)
   );

   ptt_alu u_alu (
      .base    (last_tick_ff),
      .addend  (is_tick ? period_rd : interval_ff),
      .limit   (dl_rd),
      .sum_sat (dl_sum),
      .ge      (dl_ge)
   );

   ptt_ram #(
      .WIDTH (2*IDW),
      .DEPTH (NUM_TIMERS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (add_hit),
      .wr_addr (eval_idx),
      .wr_data ({next_id_ff, interval_ff}),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (meta_rd)
   );

   ptt_ram #(
      .WIDTH (TW),
      .DEPTH (NUM_TIMERS)
   ) u_dl_ram (
      .clock   (clock),
      .wr_en   (add_hit || fire_go),
      .wr_addr (eval_idx),
      .wr_data (dl_sum),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (dl_rd)
   );

   always_comb begin
      op_in        = op_ff;
      interval_in  = interval_ff;
      cid_in       = cid_ff;
      last_tick_in = last_tick_ff;
      next_id_in   = next_id_ff;
      active_in    = active_ff;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_id_in   = pend_id_ff;
      pend_ok_in   = pend_ok_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         op_in       = req_if.operation;
         interval_in = req_if.period_ms;
         cid_in      = req_if.cancel_id;
         pend_id_in  = '0;
         pend_ok_in  = 1'b0;
         pend_vld_in = 1'b0;
         if (req_if.operation == ptt_pkg::OP_TICK) begin
            last_tick_in = req_if.now_ms;
         end
         // add and cancel start with their failure reply
         if (req_if.operation == ptt_pkg::OP_ADD) begin
            pend_vld_in  = 1'b1;
            pend_kind_in = ptt_pkg::KIND_ADD;
         end else if (req_if.operation == ptt_pkg::OP_CANCEL) begin
            pend_vld_in  = 1'b1;
            pend_kind_in = ptt_pkg::KIND_CANCEL;
            pend_id_in   = req_if.cancel_id;
         end
      end

      if (add_hit) begin
         active_in[eval_idx] = 1'b1;
         pend_id_in          = next_id_ff;
         pend_ok_in          = 1'b1;
         next_id_in          = next_id_inc;
      end

      if (cancel_hit) begin
         active_in[eval_idx] = 1'b0;
         pend_ok_in          = 1'b1;
      end

      if (rsp_if.ready) rsp_vld_in = 1'b0;

      // the newest fire is held back until it is known whether it is the last
      if (fire_go) begin
         if (pend_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_kind_in = pend_kind_ff;
            rsp_id_in   = pend_id_ff;
            rsp_ok_in   = pend_ok_ff;
            rsp_last_in = 1'b0;
         end
         pend_vld_in  = 1'b1;
         pend_kind_in = ptt_pkg::KIND_FIRE;
         pend_id_in   = id_rd;
         pend_ok_in   = 1'b0;
      end

      if (ctrl.fin && out_free) begin
         rsp_vld_in  = 1'b1;
         rsp_last_in = 1'b1;
         if (pend_vld_ff) begin
            rsp_kind_in = pend_kind_ff;
            rsp_id_in   = pend_id_ff;
            rsp_ok_in   = pend_ok_ff;
         end else begin
            rsp_kind_in = ptt_pkg::KIND_NOFIRE;
            rsp_id_in   = '0;
            rsp_ok_in   = 1'b0;
         end
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff <= '0;
         next_id_ff   <= IDW'(1);
         active_ff    <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         last_tick_ff <= last_tick_in;
         next_id_ff   <= next_id_in;
         active_ff    <= active_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      op_ff        <= op_in;
      interval_ff  <= interval_in;
      cid_ff       <= cid_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_ok_ff   <= pend_ok_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_if.ready  = ctrl.idle;
   assign rsp_if.valid  = rsp_vld_ff;
   assign rsp_if.kind   = rsp_kind_ff;
   assign rsp_if.tmr_id = rsp_id_ff;
   assign rsp_if.ok     = rsp_ok_ff;
   assign rsp_if.last   = rsp_last_ff;

   assign add_ok_out = rsp_vld_ff && (rsp_kind_ff == ptt_pkg::KIND_ADD) && rsp_ok_ff;
   assign single_out = rsp_vld_ff && (rsp_kind_ff != ptt_pkg::KIND_FIRE);

   `PTT_ASSERT_IMP(a_id_nonzero, clock, reset, 1'b1, next_id_ff != '0, "next identifier is zero")
   `PTT_ASSERT_IMP(a_add_ok_id, clock, reset, add_ok_out, rsp_id_ff != '0, "add ok without id")
   `PTT_ASSERT_IMP(a_reply_last, clock, reset, single_out, rsp_last_ff, "reply not marked last")
   `PTT_ASSERT_IMP(a_stall_cause, clock, reset, stat.stall, !out_free && pend_vld_ff, "bad stall")

endmodule

FILE: dv/timer_table_checker.sv
`timescale 1ns / 1ps

module timer_table_checker #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
   input  logic clock,
   input  logic reset,
   ptt_req_if   req_if,
   ptt_rsp_if   rsp_if,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      logic [ptt_pkg::KIND_W-1:0] kind;
      logic [ptt_pkg::ID_W-1:0]   tmr_id;
      logic                       ok;
      logic                       last;
   } timer_result_type;

   // shadow of the timer table
   logic                         slot_busy     [NUM_TIMERS];
   logic [ptt_pkg::ID_W-1:0]     slot_ident    [NUM_TIMERS];
   logic [ptt_pkg::ID_W-1:0]     slot_period   [NUM_TIMERS];
   logic [ptt_pkg::TIME_W-1:0]   slot_deadline [NUM_TIMERS];
   logic [ptt_pkg::ID_W-1:0]     next_ident;
   logic [ptt_pkg::TIME_W-1:0]   last_tick_ms;

   timer_result_type expected_results[$];
   int               results_seen;

   initial mismatch_count = 0;

   function automatic timer_result_type make_result(
      input logic [ptt_pkg::KIND_W-1:0] kind,
      input logic [ptt_pkg::ID_W-1:0]   tmr_id,
      input logic                       ok,
      input logic                       last
   );
      timer_result_type r;
      r.kind   = kind;
      r.tmr_id = tmr_id;
      r.ok     = ok;
      r.last   = last;
      return r;
   endfunction

   // deadline sums clamp at the top of the time range
   function automatic logic [ptt_pkg::TIME_W-1:0] deadline_after(
      input logic [ptt_pkg::TIME_W-1:0] base,
      input logic [ptt_pkg::ID_W-1:0]   span
   );
      logic [ptt_pkg::TIME_W:0] sum;
      sum = {1'b0, base} + {{(ptt_pkg::TIME_W + 1 - ptt_pkg::ID_W){1'b0}}, span};
      return sum[ptt_pkg::TIME_W] ? {ptt_pkg::TIME_W{1'b1}} : sum[ptt_pkg::TIME_W-1:0];
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] exp_val,
                                  input logic [63:0] got_val);
      $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
               $time, results_seen, field, exp_val, got_val);
      mismatch_count++;
   endtask

   task automatic predict_timer_results(
      input logic [ptt_pkg::OP_W-1:0]   op,
      input logic [ptt_pkg::ID_W-1:0]   interval,
      input logic [ptt_pkg::ID_W-1:0]   cid,
      input logic [ptt_pkg::TIME_W-1:0] now
   );
      logic found;
      int   hits;
      int   seen;
      found = 1'b0;
      hits  = 0;
      seen  = 0;
      case (op)
         ptt_pkg::OP_ADD: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (!found && !slot_busy[i]) begin
                  found            = 1'b1;
                  slot_busy[i]     = 1'b1;
                  slot_ident[i]    = next_ident;
                  slot_period[i]   = interval;
                  slot_deadline[i] = deadline_after(last_tick_ms, interval);
                  expected_results.push_back(
                     make_result(ptt_pkg::KIND_ADD, next_ident, 1'b1, 1'b1));
                  next_ident = next_ident + 1;
                  if (next_ident == '0)
                     next_ident = 1;
               end
            end
            if (!found)
               expected_results.push_back(make_result(ptt_pkg::KIND_ADD, '0, 1'b0, 1'b1));
         end
         ptt_pkg::OP_CANCEL: begin
            if (cid != '0) begin
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (!found && slot_busy[i] && slot_ident[i] == cid) begin
                     found        = 1'b1;
                     slot_busy[i] = 1'b0;
                  end
               end
            end
            expected_results.push_back(make_result(ptt_pkg::KIND_CANCEL, cid, found, 1'b1));
         end
         ptt_pkg::OP_TICK: begin
            last_tick_ms = now;
            for (int i = 0; i < NUM_TIMERS; i++)
               if (slot_busy[i] && now >= slot_deadline[i])
                  hits++;
            if (hits == 0) begin
               expected_results.push_back(make_result(ptt_pkg::KIND_NOFIRE, '0, 1'b0, 1'b1));
            end else begin
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (slot_busy[i] && now >= slot_deadline[i]) begin
                     seen++;
                     expected_results.push_back(
                        make_result(ptt_pkg::KIND_FIRE, slot_ident[i], 1'b0, seen == hits));
                     slot_deadline[i] = deadline_after(now, slot_period[i]);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_timer_result();
      timer_result_type exp_r;
      if (expected_results.size() == 0) begin
         report_mismatch("no transaction pending, kind", '0, 64'(rsp_if.kind));
      end else begin
         exp_r = expected_results.pop_front();
         if (rsp_if.kind !== exp_r.kind)
            report_mismatch("kind", 64'(exp_r.kind), 64'(rsp_if.kind));
         if (rsp_if.tmr_id !== exp_r.tmr_id)
            report_mismatch("tmr_id", 64'(exp_r.tmr_id), 64'(rsp_if.tmr_id));
         if (rsp_if.ok !== exp_r.ok)
            report_mismatch("ok", 64'(exp_r.ok), 64'(rsp_if.ok));
         if (rsp_if.last !== exp_r.last)
            report_mismatch("last", 64'(exp_r.last), 64'(rsp_if.last));
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            slot_busy[i]     = 1'b0;
            slot_ident[i]    = '0;
            slot_period[i]   = '0;
            slot_deadline[i] = '0;
         end
         next_ident   = 1;
         last_tick_ms = '0;
         results_seen = 0;
         expected_results.delete();
      end else begin
         // results belong to older transactions, so drain before predicting
         if (rsp_if.valid && rsp_if.ready)
            check_timer_result();
         if (req_if.valid && req_if.ready)
            predict_timer_results(req_if.operation, req_if.period_ms,
                                  req_if.cancel_id, req_if.now_ms);
      end
      pending_count <= expected_results.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_ITEMS   = 355;
   localparam int END_SETTLE     = 40;
   localparam logic [ptt_pkg::TIME_W-1:0] TIME_TOP = {ptt_pkg::TIME_W{1'b1}};

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;

   bit   hold_rsp_long;
   bit   steady_send;
   int   adds_sent;
   int   items_sent;
   logic [ptt_pkg::TIME_W-1:0] now_ms;

   ptt_req_if req_if();
   ptt_rsp_if rsp_if();

   periodic_timer_table_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   timer_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap(input bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ptt_pkg::TIME_W-1:0] any_time();
      logic [ptt_pkg::TIME_W-1:0] t;
      t[47:32] = 16'($urandom_range(0, 16'hFFFF));
      t[31:0]  = $urandom;
      return t;
   endfunction

   task automatic send_request(
      input logic [ptt_pkg::OP_W-1:0]   op,
      input logic [ptt_pkg::ID_W-1:0]   interval,
      input logic [ptt_pkg::ID_W-1:0]   cid,
      input logic [ptt_pkg::TIME_W-1:0] now
   );
      int gap;
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.period_ms <= interval;
      req_if.cancel_id <= cid;
      req_if.now_ms    <= now;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      if (op == ptt_pkg::OP_ADD)
         adds_sent++;
      gap = pick_gap(steady_send);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until the table has answered everything
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   task automatic random_transaction();
      int r;
      int step;
      int lo;
      logic [ptt_pkg::ID_W-1:0] cid;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         send_request(ptt_pkg::OP_UNUSED, $urandom, $urandom, any_time());
         items_sent++;
         return;
      end
      if (r < 34) begin
         send_request(ptt_pkg::OP_ADD,
                      ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40),
                      $urandom, any_time());
      end else if (r < 58) begin
         lo = (adds_sent > 24) ? adds_sent - 24 : 0;
         if ($urandom_range(0, 9) == 0)
            cid = $urandom;
         else
            cid = $urandom_range(lo, adds_sent + 1);
         send_request(ptt_pkg::OP_CANCEL, $urandom, cid, any_time());
      end else begin
         r = $urandom_range(0, 99);
         step = $urandom_range(0, 30);
         if (r < 85)
            now_ms = (TIME_TOP - now_ms < step) ? TIME_TOP : now_ms + step;
         else if (r < 92)
            now_ms = (now_ms < step) ? '0 : now_ms - step;
         else if (r < 96)
            now_ms = any_time();
         else
            now_ms = TIME_TOP - $urandom_range(0, 40);
         send_request(ptt_pkg::OP_TICK, $urandom, $urandom, now_ms);
      end
      items_sent++;
   endtask

   // result side: random stalls, long quiet stretches, one long hold-off
   initial begin
      int stall;
      int run;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = pick_gap(1'b0);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      hold_rsp_long = 1'b0;
      steady_send   = 1'b0;
      adds_sent     = 0;
      items_sent    = 0;
      now_ms        = '0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.operation <= ptt_pkg::OP_ADD;
      req_if.period_ms <= '0;
      req_if.cancel_id <= '0;
      req_if.now_ms    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, bad cancels, fill to full, saturation, time going back
      send_request(ptt_pkg::OP_TICK,   '0, '0, '0);
      send_request(ptt_pkg::OP_CANCEL, '0, '0, '0);
      send_request(ptt_pkg::OP_CANCEL, '0, 7, '0);
      send_request(ptt_pkg::OP_ADD,    '0, '1, TIME_TOP);
      send_request(ptt_pkg::OP_ADD,    '1, '0, '0);
      send_request(ptt_pkg::OP_TICK,   '0, '0, '0);
      for (int i = 1; i <= 14; i++)
         send_request(ptt_pkg::OP_ADD, i * 3, '0, '0);
      send_request(ptt_pkg::OP_ADD,    5, '0, '0);
      send_request(ptt_pkg::OP_TICK,   '0, '0, 25);
      send_request(ptt_pkg::OP_CANCEL, '0, 3, '0);
      send_request(ptt_pkg::OP_TICK,   '0, '0, TIME_TOP - 1);
      send_request(ptt_pkg::OP_TICK,   '0, '0, TIME_TOP);
      send_request(ptt_pkg::OP_TICK,   '0, '0, 10);
      send_request(ptt_pkg::OP_UNUSED, '1, '1, TIME_TOP);
      send_request(ptt_pkg::OP_ADD,    12, '0, '0);
      now_ms = 10;
      drain_results();

      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0)
            steady_send = !steady_send;
         if (items_sent == 120 && !hold_rsp_long) begin
            hold_rsp_long = 1'b1;
            steady_send   = 1'b1;
         end
         if (items_sent == 250)
            drain_results();
         random_transaction();
      end

      drain_results();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
